// File: sv/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg - shared types and constants of the index run allocator
// Request modes, status codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none
package ira_pkg;
   localparam int CAPACITY = 1024;
   localparam int MODE_W = 3;
   localparam int IDX_W  = 10;
   localparam int LEN_W  = 11;
   localparam int ST_W   = 2;

   localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FREE      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ALLOC_RUN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FREE_RUN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CONTAINS  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD  = 2'd2;
   localparam logic [ST_W-1:0] ST_OVF  = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_START = 4'd1,
      OP_STEP  = 4'd2,
      OP_DONE  = 4'd3
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic done;
   } stat_type;
endpackage
`default_nettype wire

// File: sv/ira_if.sv
// ----------------------------------------------------------------------------
// ira_req_if / ira_rsp_if - request and response channels
// Valid/ready channels carrying one request or one response.
// ----------------------------------------------------------------------------
`default_nettype none
interface ira_req_if import ira_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [IDX_W-1:0]  slot_index;
   logic [LEN_W-1:0]  run_length;
   modport source (output valid, mode, slot_index, run_length, input ready);
   modport sink   (input valid, mode, slot_index, run_length, output ready);
endinterface

interface ira_rsp_if import ira_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] result_index;
   logic [LEN_W-1:0] result_length;
   logic             present;
   logic [ST_W-1:0]  status;
   modport source (output valid, result_index, result_length, present, status,
                   input ready);
   modport sink   (input valid, result_index, result_length, present, status,
                   output ready);
endinterface
`default_nettype wire

// File: sv/ira_ctrl.sv
// ----------------------------------------------------------------------------
// ira_ctrl - request sequencer
// Accepts a request, runs the datapath until done, then holds the response.
// ----------------------------------------------------------------------------
`default_nettype none
module ira_ctrl import ira_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_START;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.op = OP_STEP;
            if (stat.done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               cmd.op   = OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_done_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && stat.done) |=> rsp_valid) else $error("done lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("rsp dropped");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
`endif
endmodule
`default_nettype wire

// File: sv/ira_dp.sv
// ----------------------------------------------------------------------------
// ira_dp - allocator datapath
// Free-list memory, mark and count registers, and the scan/sort/trim walker.
// ----------------------------------------------------------------------------
`default_nettype none
module ira_dp import ira_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output stat_type              stat,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [IDX_W-1:0] req_slot_index,
   input  wire logic [LEN_W-1:0] req_run_length,
   output logic [IDX_W-1:0]      rsp_result_index,
   output logic [LEN_W-1:0]      rsp_result_length,
   output logic                  rsp_present,
   output logic [ST_W-1:0]       rsp_status
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;

   // phases of the walker
   typedef enum logic [3:0] {
      P_DISPATCH, P_POP, P_SCAN, P_SHIFT, P_PUSHRUN, P_SORT_RD, P_SORT_CMP,
      P_SORT_WR, P_TRIM, P_TRIMCHK, P_CONT, P_FINISH
   } ph_type;

   logic [IDX_W-1:0] mem [CAPACITY];
   logic [IDX_W-1:0] rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [IDX_W-1:0] wr_data;

   ph_type           ph_ff, ph_in;
   logic             wait_ff, wait_in;  // read issued, data next cycle
   logic [CW-1:0]    hw_ff, hw_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [IDX_W-1:0] v_ff, v_in;
   logic [CW:0]      start_ff, start_in;
   logic [CW-1:0]    run_ff, run_in;
   logic             have_ff, have_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] r_idx_ff, r_idx_in;
   logic [LEN_W-1:0] r_len_ff, r_len_in;
   logic             pres_ff, pres_in;
   logic [ST_W-1:0]  st_ff, st_in;

   logic [CW+1:0] hw_plus_len;
   logic [CW+1:0] cnt_plus_len;
   logic [CW+1:0] idx_plus_len;
   assign hw_plus_len  = (CW+2)'(hw_ff) + (CW+2)'(len_ff);
   assign cnt_plus_len = (CW+2)'(cnt_ff) + (CW+2)'(len_ff);
   assign idx_plus_len = (CW+2)'(idx_ff) + (CW+2)'(len_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.done = done_ff;
   assign rsp_result_index  = r_idx_ff;
   assign rsp_result_length = r_len_ff;
   assign rsp_present       = pres_ff;
   assign rsp_status        = st_ff;

   always_comb begin
      ph_in = ph_ff; wait_in = 1'b0; hw_in = hw_ff; cnt_in = cnt_ff;
      mode_in = mode_ff; idx_in = idx_ff; len_in = len_ff;
      i_in = i_ff; j_in = j_ff; v_in = v_ff; start_in = start_ff; run_in = run_ff;
      have_in = have_ff; done_in = done_ff;
      r_idx_in = r_idx_ff; r_len_in = r_len_ff; pres_in = pres_ff; st_in = st_ff;
      rd_addr = i_ff[AW-1:0]; wr_en = 1'b0; wr_addr = cnt_ff[AW-1:0];
      wr_data = idx_ff;
      case (cmd.op)
         OP_START: begin
            mode_in = req_mode; idx_in = req_slot_index; len_in = req_run_length;
            r_idx_in = '0; r_len_in = '0; pres_in = 1'b0; st_in = ST_OK;
            i_in = '0; have_in = 1'b0; ph_in = P_DISPATCH; done_in = 1'b0;
         end
         OP_DONE: begin
            done_in = 1'b0;
            ph_in = P_DISPATCH;
         end
         OP_STEP: begin
            if (!done_ff) begin
               case (ph_ff)
                  P_DISPATCH: begin
                     done_in = 1'b1;
                     case (mode_ff)
                        MODE_ALLOC: begin
                           if (cnt_ff != '0) begin
                              cnt_in = cnt_ff - 1'b1;
                              rd_addr = AW'(cnt_ff - 1'b1);
                              wait_in = 1'b1; done_in = 1'b0; ph_in = P_POP;
                           end else if (hw_ff >= CW'(CAPACITY)) begin
                              st_in = ST_FULL;
                           end else begin
                              r_idx_in = IDX_W'(hw_ff); r_len_in = LEN_W'(1);
                              hw_in = hw_ff + 1'b1;
                           end
                        end
                        MODE_FREE: begin
                           if (idx_ff == '0 || CW'(idx_ff) >= hw_ff) begin
                              st_in = ST_BAD;
                           end else if (cnt_ff >= CW'(CAPACITY)) begin
                              st_in = ST_OVF;
                           end else begin
                              wr_en = 1'b1; cnt_in = cnt_ff + 1'b1;
                           end
                        end
                        MODE_ALLOC_RUN: begin
                           if (len_ff != '0) begin
                              done_in = 1'b0; ph_in = P_SCAN;
                              rd_addr = '0; wait_in = 1'b1;
                           end
                        end
                        MODE_FREE_RUN: begin
                           if (len_ff != '0 && (idx_ff == '0 ||
                               idx_plus_len > (CW+2)'(hw_ff))) begin
                              st_in = ST_BAD;
                           end else if (cnt_plus_len > (CW+2)'(CAPACITY)) begin
                              st_in = ST_OVF;
                           end else begin
                              done_in = 1'b0; ph_in = P_PUSHRUN; j_in = '0;
                           end
                        end
                        MODE_CONTAINS: begin
                           if (idx_ff != '0 && CW'(idx_ff) < hw_ff) begin
                              pres_in = 1'b1; done_in = 1'b0; ph_in = P_CONT;
                              rd_addr = '0; wait_in = 1'b1;
                           end
                        end
                        MODE_CLEAR: begin
                           hw_in = CW'(1); cnt_in = '0;
                        end
                        default: ;
                     endcase
                  end
                  P_POP: begin
                     r_idx_in = rd_data_ff; r_len_in = LEN_W'(1);
                     done_in = 1'b1; ph_in = P_DISPATCH;
                  end
                  P_CONT: begin
                     // i_ff is the entry whose data is now in rd_data_ff
                     if (i_ff >= cnt_ff) begin
                        done_in = 1'b1; ph_in = P_DISPATCH;
                     end else if (!wait_ff) begin
                        rd_addr = i_ff[AW-1:0]; wait_in = 1'b1;
                     end else if (rd_data_ff == idx_ff) begin
                        pres_in = 1'b0; done_in = 1'b1; ph_in = P_DISPATCH;
                     end else begin
                        i_in = i_ff + 1'b1; rd_addr = AW'(i_ff + 1'b1); wait_in = 1'b1;
                     end
                  end
                  P_SCAN: begin
                     if (i_ff >= cnt_ff) begin
                        done_in = 1'b1; ph_in = P_DISPATCH;
                        if (hw_plus_len > (CW+2)'(CAPACITY)) begin
                           st_in = ST_FULL;
                        end else begin
                           r_idx_in = IDX_W'(hw_ff); r_len_in = len_ff;
                           hw_in = CW'(hw_plus_len);
                        end
                     end else if (!wait_ff) begin
                        rd_addr = i_ff[AW-1:0]; wait_in = 1'b1;
                     end else begin
                        logic [CW-1:0] nrun;
                        logic [CW:0]   nstart;
                        if (have_ff && ((CW+1)'(rd_data_ff) ==
                            start_ff + (CW+1)'(run_ff))) begin
                           nrun = run_ff + 1'b1; nstart = start_ff;
                        end else begin
                           nrun = CW'(1); nstart = (CW+1)'(rd_data_ff);
                        end
                        have_in = 1'b1; run_in = nrun; start_in = nstart;
                        if (LEN_W'(nrun) == len_ff) begin
                           r_idx_in = IDX_W'(nstart); r_len_in = LEN_W'(nrun);
                           j_in = i_ff + 1'b1 - nrun;
                           i_in = i_ff + 1'b1;   // source of the shift
                           ph_in = P_SHIFT;
                        end else begin
                           i_in = i_ff + 1'b1; rd_addr = AW'(i_ff + 1'b1);
                           wait_in = 1'b1;
                        end
                     end
                  end
                  P_SHIFT: begin
                     // copy entry i to j until i reaches the count
                     if (i_ff >= cnt_ff) begin
                        cnt_in = cnt_ff - run_ff;
                        done_in = 1'b1; ph_in = P_DISPATCH;
                     end else if (!wait_ff) begin
                        rd_addr = i_ff[AW-1:0]; wait_in = 1'b1;
                     end else begin
                        wr_en = 1'b1; wr_addr = j_ff[AW-1:0]; wr_data = rd_data_ff;
                        i_in = i_ff + 1'b1; j_in = j_ff + 1'b1;
                     end
                  end
                  P_PUSHRUN: begin
                     if (LEN_W'(j_ff) >= len_ff) begin
                        cnt_in = CW'(cnt_plus_len); i_in = CW'(1); ph_in = P_SORT_RD;
                     end else begin
                        wr_en = 1'b1; wr_addr = AW'(cnt_ff + j_ff);
                        wr_data = IDX_W'(idx_ff + IDX_W'(j_ff));
                        j_in = j_ff + 1'b1;
                     end
                  end
                  P_SORT_RD: begin
                     // fetch v = list[i]
                     if (i_ff >= cnt_ff) begin
                        ph_in = P_TRIM;
                     end else if (!wait_ff) begin
                        rd_addr = i_ff[AW-1:0]; wait_in = 1'b1;
                     end else begin
                        v_in = rd_data_ff; j_in = i_ff;
                        ph_in = P_SORT_CMP;
                     end
                  end
                  P_SORT_CMP: begin
                     // compare list[j-1] with v
                     if (j_ff == '0) begin
                        ph_in = P_SORT_WR;
                     end else if (!wait_ff) begin
                        rd_addr = AW'(j_ff - 1'b1); wait_in = 1'b1;
                     end else if (rd_data_ff > v_ff) begin
                        wr_en = 1'b1; wr_addr = j_ff[AW-1:0]; wr_data = rd_data_ff;
                        j_in = j_ff - 1'b1;
                     end else begin
                        ph_in = P_SORT_WR;
                     end
                  end
                  P_SORT_WR: begin
                     wr_en = 1'b1; wr_addr = j_ff[AW-1:0]; wr_data = v_ff;
                     i_in = i_ff + 1'b1; ph_in = P_SORT_RD;
                  end
                  P_TRIM: begin
                     if (cnt_ff == '0) begin
                        done_in = 1'b1; ph_in = P_DISPATCH;
                     end else begin
                        rd_addr = AW'(cnt_ff - 1'b1); wait_in = 1'b1; ph_in = P_TRIMCHK;
                     end
                  end
                  P_TRIMCHK: begin
                     ph_in = P_TRIM;
                     if (CW'(rd_data_ff) >= hw_ff) begin
                        cnt_in = cnt_ff - 1'b1;
                     end else if (hw_ff > CW'(1) && CW'(rd_data_ff) == hw_ff - 1'b1) begin
                        cnt_in = cnt_ff - 1'b1; hw_in = hw_ff - 1'b1;
                     end else begin
                        done_in = 1'b1; ph_in = P_DISPATCH;
                     end
                  end
                  default: begin
                     done_in = 1'b1; ph_in = P_DISPATCH;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= P_DISPATCH; wait_ff <= 1'b0; done_ff <= 1'b0;
         hw_ff <= CW'(1); cnt_ff <= '0;
      end else begin
         ph_ff <= ph_in; wait_ff <= wait_in; done_ff <= done_in;
         hw_ff <= hw_in; cnt_ff <= cnt_in;
      end
      mode_ff <= mode_in; idx_ff <= idx_in; len_ff <= len_in;
      i_ff <= i_in; j_ff <= j_in; v_ff <= v_in; start_ff <= start_in;
      run_ff <= run_in; have_ff <= have_in;
      r_idx_ff <= r_idx_in; r_len_ff <= r_len_in; pres_ff <= pres_in; st_ff <= st_in;
   end

`ifndef SYNTH
   a_hw_range: assert property (@(posedge clock) disable iff (reset)
      (hw_ff >= CW'(1) && hw_ff <= CW'(CAPACITY))) else $error("mark out of range");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY)) else $error("count out of range");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_STEP && ph_ff == P_DISPATCH && !done_ff && mode_ff == MODE_CLEAR)
      |=> (hw_ff == CW'(1) && cnt_ff == '0)) else $error("clear failed");
`endif
endmodule
`default_nettype wire

// File: sv/index_run_allocator_core.sv
// ----------------------------------------------------------------------------
// index_run_allocator_core - slot index allocator with free list and runs
// Hands out table slot indices from a free-list stack or a high-water mark.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Alloc, free, clear and rejected
// requests pass through the run state and the registered done flag before
// the response is presented, and the next request is taken in the cycle
// after the response leaves; a single alloc popping the free list also waits
// for the memory read. Alloc-run and contains walk the free list through its
// single registered read port, and removing a run moves each entry above it
// down. Free-run writes one slot per cycle, then insertion-sorts the list and
// trims the tail.
// The free list memory needs no clearing after reset; only entries below the
// fill count are ever read.
`default_nettype none
module index_run_allocator_core import ira_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   ira_req_if.sink   req,
   ira_rsp_if.source rsp
);
   cmd_type  cmd;
   stat_type stat;

   // sequence each request: accept, run, hold the response
   ira_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // free list, mark, count and the walker
   ira_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req.mode),
      .req_slot_index    (req.slot_index),
      .req_run_length    (req.run_length),
      .rsp_result_index  (rsp.result_index),
      .rsp_result_length (rsp.result_length),
      .rsp_present       (rsp.present),
      .rsp_status        (rsp.status)
   );
endmodule
`default_nettype wire

// File: test/index_run_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_run_allocator_core_tb - regression bench for the slot index allocator
// Drives alloc, free, run, contains and clear requests through the request
// channel, predicts every response from a behavioral copy of the allocator
// state and checks each response field by field, under random stalls.
// ----------------------------------------------------------------------------
module index_run_allocator_core_tb;
   import ira_pkg::*;

   localparam int CAP          = CAPACITY;
   localparam int IDLE_LIMIT   = 3000000;  // a full-list sort is well below this
   localparam int RANDOM_COUNT = 830;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  slot_index;
      logic [LEN_W-1:0]  run_length;
      bit                drain;       // marker: pause until all responses are back
   } request_type;

   typedef struct {
      logic [IDX_W-1:0] result_index;
      logic [LEN_W-1:0] result_length;
      logic             present;
      logic [ST_W-1:0]  status;
   } response_type;

   logic clock;
   logic reset;

   ira_req_if req ();
   ira_rsp_if rsp ();

   index_run_allocator_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // Allocator state as the bench sees it
   int high_mark;
   int free_fill;
   int free_slots [CAP];

   request_type  pending_q [$];
   response_type expected_q [$];

   int req_count;
   int rsp_count;
   int mismatches;
   int idle_cycles;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   bit hold_done;
   int full_seen;
   int bad_seen;
   int ovf_seen;
   int present_seen;

   // Sort the free list ascending, then drop tail entries at or above the
   // mark, pulling the mark down over freed slots just below it.
   function automatic void sort_and_trim_free_list();
      int i;
      int j;
      int v;
      for (i = 1; i < free_fill; i++) begin
         v = free_slots[i];
         j = i;
         while (j > 0 && free_slots[j-1] > v) begin
            free_slots[j] = free_slots[j-1];
            j--;
         end
         free_slots[j] = v;
      end
      while (free_fill != 0) begin
         v = free_slots[free_fill-1];
         if (v >= high_mark) begin
            free_fill--;
         end else if (high_mark > 1 && v == high_mark - 1) begin
            free_fill--;
            high_mark--;
         end else begin
            break;
         end
      end
   endfunction

   // Apply one request to the bench state and return the response it causes
   function automatic response_type predict_allocation(request_type r);
      response_type e;
      int        idx;
      int        len;
      int        i;
      int        j;
      int        start;
      int        cnt;
      int        v;
      bit        found;
      bit        have;
      int        r_idx;
      int        r_len;
      idx   = int'(r.slot_index);
      len   = int'(r.run_length);
      r_idx = 0;
      r_len = 0;
      e.present = 1'b0;
      e.status  = ST_OK;
      case (r.mode)
         MODE_ALLOC: begin
            if (free_fill > 0) begin
               free_fill--;
               r_idx = free_slots[free_fill];
               r_len = 1;
            end else if (high_mark >= CAP) begin
               e.status = ST_FULL;
            end else begin
               r_idx = high_mark;
               r_len = 1;
               high_mark++;
            end
         end
         MODE_FREE: begin
            if (idx == 0 || idx >= high_mark) begin
               e.status = ST_BAD;
            end else if (free_fill >= CAP) begin
               e.status = ST_OVF;
            end else begin
               free_slots[free_fill] = idx;
               free_fill++;
            end
         end
         MODE_ALLOC_RUN: begin
            if (len != 0) begin
               found = 0;
               have  = 0;
               start = 0;
               cnt   = 0;
               // scan bottom to top; a repeated index starts a new run
               for (i = 0; i < free_fill && !found; i++) begin
                  v = free_slots[i];
                  if (have && v == start + cnt) begin
                     cnt++;
                  end else begin
                     start = v;
                     cnt   = 1;
                     have  = 1;
                  end
                  if (cnt == len) begin
                     for (j = i + 1 - cnt; j + cnt < free_fill; j++)
                        free_slots[j] = free_slots[j+cnt];
                     free_fill -= cnt;
                     r_idx = start;
                     r_len = cnt;
                     found = 1;
                  end
               end
               if (!found) begin
                  if (high_mark + len > CAP) begin
                     e.status = ST_FULL;
                  end else begin
                     r_idx = high_mark;
                     r_len = len;
                     high_mark += len;
                  end
               end
            end
         end
         MODE_FREE_RUN: begin
            if (len != 0 && (idx == 0 || idx + len > high_mark)) begin
               e.status = ST_BAD;
            end else if (free_fill + len > CAP) begin
               e.status = ST_OVF;
            end else begin
               for (i = 0; i < len; i++)
                  free_slots[free_fill+i] = idx + i;
               free_fill += len;
               sort_and_trim_free_list();
            end
         end
         MODE_CONTAINS: begin
            if (idx != 0 && idx < high_mark) begin
               e.present = 1'b1;
               for (i = 0; i < free_fill; i++) begin
                  if (free_slots[i] == idx) begin
                     e.present = 1'b0;
                     break;
                  end
               end
            end
         end
         MODE_CLEAR: begin
            high_mark = 1;
            free_fill = 0;
         end
         default: ;
      endcase
      e.result_index  = r_idx[IDX_W-1:0];
      e.result_length = r_len[LEN_W-1:0];
      return e;
   endfunction

   function automatic void queue_request(logic [MODE_W-1:0] mode, int idx, int len);
      request_type r;
      r.mode       = mode;
      r.slot_index = idx[IDX_W-1:0];
      r.run_length = len[LEN_W-1:0];
      r.drain      = 0;
      pending_q.push_back(r);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle rates follow the request count: receiver-heavy idling first, then
   // sender-heavy, then none at all.
   always @(*) begin
      if (req_count < 280) begin
         send_idle_pct = 28;
         recv_idle_pct = 51;
      end else if (req_count < 560) begin
         send_idle_pct = 51;
         recv_idle_pct = 28;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Request driver: present the next pending request once the current one
   // has been taken. A drain marker holds the channel idle until every
   // expected response has come back.
   always @(posedge clock) begin
      if (reset) begin
         req.valid      <= 1'b0;
         req.mode       <= '0;
         req.slot_index <= '0;
         req.run_length <= '0;
      end else if (!req.valid || req.ready) begin
         if (pending_q.size() > 0 && pending_q[0].drain) begin
            req.valid <= 1'b0;
            if (!req.valid && req_count == rsp_count)
               void'(pending_q.pop_front());
         end else if (pending_q.size() > 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req.valid      <= 1'b1;
            req.mode       <= pending_q[0].mode;
            req.slot_index <= pending_q[0].slot_index;
            req.run_length <= pending_q[0].run_length;
            void'(pending_q.pop_front());
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Predict on each accepted request, in acceptance order
   always @(posedge clock) begin
      request_type r;
      if (!reset && req.valid && req.ready) begin
         r.mode       = req.mode;
         r.slot_index = req.slot_index;
         r.run_length = req.run_length;
         r.drain      = 0;
         expected_q.push_back(predict_allocation(r));
         req_count <= req_count + 1;
      end
   end

   // Response side: random backpressure, one long hold-off, and the check
   // of each response against the oldest expectation.
   always @(posedge clock) begin
      response_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (!hold_done && rsp_count == 200) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            rsp.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end

         if (rsp.valid && rsp.ready) begin
            rsp_count <= rsp_count + 1;
            if (rsp.status == ST_FULL) full_seen++;
            if (rsp.status == ST_BAD)  bad_seen++;
            if (rsp.status == ST_OVF)  ovf_seen++;
            if (rsp.present)           present_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: response with nothing expected: ",
                            "idx %0d len %0d pres %0d st %0d"},
                           rsp.result_index, rsp.result_length, rsp.present,
                           rsp.status);
            end else begin
               e = expected_q.pop_front();
               if (rsp.result_index !== e.result_index ||
                   rsp.result_length !== e.result_length ||
                   rsp.present !== e.present || rsp.status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: response %0d: expected idx %0d len %0d ",
                               "pres %0d st %0d, got idx %0d len %0d pres %0d st %0d"},
                              rsp_count, e.result_index, e.result_length, e.present,
                              e.status, rsp.result_index, rsp.result_length,
                              rsp.present, rsp.status);
               end
            end
         end
      end
   end

   // Watchdog: stop when no request or response moves for too long
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
            $display("index_run_allocator_core regression: fail");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      request_type marker;
      int       k;
      int       r;
      high_mark    = 1;
      free_fill    = 0;
      req_count    = 0;
      rsp_count    = 0;
      mismatches   = 0;
      idle_cycles  = 0;
      hold_left    = 0;
      hold_done    = 0;
      full_seen    = 0;
      bad_seen     = 0;
      ovf_seen     = 0;
      present_seen = 0;
      req.valid      = 1'b0;
      req.mode       = '0;
      req.slot_index = '0;
      req.run_length = '0;
      rsp.ready      = 1'b0;
      reset          = 1'b1;

      // Directed: edges of the fields and every special case
      queue_request(MODE_ALLOC, 0, 0);
      queue_request(MODE_CONTAINS, 1, 0);
      queue_request(MODE_CONTAINS, 0, 0);
      queue_request(MODE_FREE, 0, 0);           // reserved slot
      queue_request(MODE_FREE, 1023, 0);        // above the mark
      queue_request(MODE_FREE, 1, 0);
      queue_request(MODE_FREE, 1, 0);           // double free goes through
      queue_request(MODE_CONTAINS, 1, 0);
      queue_request(MODE_ALLOC, 0, 0);          // pop from the free list
      queue_request(MODE_ALLOC_RUN, 0, 0);      // empty run
      queue_request(MODE_ALLOC_RUN, 0, 1024);   // too long: full
      queue_request(MODE_ALLOC_RUN, 0, 3);      // fresh run
      queue_request(MODE_FREE_RUN, 2, 3);       // trim lowers the mark to 1
      queue_request(MODE_FREE_RUN, 0, 0);       // empty run still sorts
      queue_request(MODE_FREE_RUN, 0, 2);       // run from the reserved slot
      queue_request(3'd6, 1023, 2047);          // unused modes
      queue_request(3'd7, 1023, 2047);
      queue_request(MODE_ALLOC_RUN, 0, 1023);   // fill the table
      queue_request(MODE_ALLOC, 0, 0);          // table full
      queue_request(MODE_FREE_RUN, 1, 500);
      queue_request(MODE_FREE_RUN, 1, 600);     // list would overflow
      queue_request(MODE_FREE_RUN, 1, 524);     // list exactly full
      queue_request(MODE_FREE, 5, 0);           // overflow on a single free
      queue_request(MODE_CONTAINS, 1023, 0);
      queue_request(MODE_ALLOC_RUN, 0, 2);      // repeated entries in the scan
      queue_request(MODE_CLEAR, 0, 0);

      // Random: mostly in-range requests on a small table, cleared now and
      // then so the free list stays short; a few out-of-range fields.
      for (k = 0; k < RANDOM_COUNT; k++) begin
         if (k == 450) begin
            marker       = pending_q[0];
            marker.drain = 1;
            pending_q.push_back(marker);
         end
         r = $urandom_range(0, 99);
         if (r < 25)
            queue_request(MODE_ALLOC, $urandom, $urandom);
         else if (r < 40)
            queue_request(MODE_FREE, ($urandom_range(0, 9) < 7) ?
                          $urandom_range(1, 40) : $urandom, 0);
         else if (r < 55)
            queue_request(MODE_ALLOC_RUN, 0, ($urandom_range(0, 19) == 0) ?
                          $urandom : $urandom_range(1, 6));
         else if (r < 68)
            queue_request(MODE_FREE_RUN, $urandom_range(0, 30),
                          ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 6));
         else if (r < 90)
            queue_request(MODE_CONTAINS, ($urandom_range(0, 9) == 0) ?
                          $urandom : $urandom_range(0, 40), 0);
         else if (r < 96)
            queue_request(MODE_CLEAR, $urandom, $urandom);
         else
            queue_request(MODE_CONTAINS, $urandom_range(1, 3), $urandom);
         if ($urandom_range(0, 99) == 0)
            queue_request(MODE_W'($urandom_range(6, 7)), $urandom, $urandom);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to drain and every response to arrive
      while (pending_q.size() != 0 || req.valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d requests over alloc, free, run, contains and clear modes;",
               req_count);
      $display("responses: %0d full, %0d bad index, %0d overflow, %0d present",
               full_seen, bad_seen, ovf_seen, present_seen);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("index_run_allocator_core regression: pass");
      end else begin
         $display("ERROR: %0d mismatches, %0d responses missing",
                  mismatches, expected_q.size());
         $display("index_run_allocator_core regression: fail");
      end
      $finish;
   end

endmodule
